// ===== rtl/core/kce_pkg.sv =====
// kce_pkg: shared widths, register indexes, types and constant tables for the
// kirsch compass edge detector. No dependencies; used by every rtl/core file.
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

   localparam int PIX_W     = 8;
   localparam int SIZE_W    = 12;
   localparam int CSR_IDX_W = 2;
   localparam int RESP_W    = 14;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd2;

   // 2^16/3 rounded up, exact floor(x/3) for x below 6144
   localparam logic [14:0] MAG_RECIP = 15'd21846;

   // ring around the center, clockwise from top-left, as window positions
   localparam logic [3:0] RING_POS [8] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3};

   // floor(index * 255 / 8)
   localparam logic [PIX_W-1:0] DIR_CODE [8] = '{8'd0, 8'd31, 8'd63, 8'd95,
                                                 8'd127, 8'd159, 8'd191, 8'd223};

   // 3x3 window, element k is row k/3, column k%3, column 2 newest
   typedef logic [8:0][PIX_W-1:0] window_type;

   // where a result's value comes from
   typedef enum logic [1:0] {
      SRC_KIRSCH,
      SRC_CENTER,
      SRC_UPPER,
      SRC_MIDDLE
   } src_type;

   // item handed from the window stage to the compass pipeline
   typedef struct packed {
      logic             kirsch;
      logic [PIX_W-1:0] pass_value;
      logic             frame_end;
      window_type       win;
   } cmp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/kce_line_store.sv =====
// kce_line_store: the two line memories (upper and middle row), one write and
// one registered read per cycle, shared address for both. Uses kce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kce_line_store #(
   parameter int MAX_WIDTH = kce_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   input  wire logic [kce_pkg::PIX_W-1:0]      wr_upper,
   input  wire logic [kce_pkg::PIX_W-1:0]      wr_middle,
   output logic      [kce_pkg::PIX_W-1:0]      rd_upper,
   output logic      [kce_pkg::PIX_W-1:0]      rd_middle
);

   logic [kce_pkg::PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [kce_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [kce_pkg::PIX_W-1:0] rd_upper_ff;
   logic [kce_pkg::PIX_W-1:0] rd_middle_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= wr_upper;
         middle_mem[wr_addr] <= wr_middle;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_upper_ff  <= upper_mem[rd_addr];
         rd_middle_ff <= middle_mem[rd_addr];
      end
   end

   assign rd_upper  = rd_upper_ff;
   assign rd_middle = rd_middle_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kce_compass.sv =====
// kce_compass: compass pipeline (window, responses, arg-max) with a result register
// that takes the scaled value, and valid/ready flow control. Uses kce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kce_compass (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      mode,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire kce_pkg::cmp_item_type     in_item,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [kce_pkg::PIX_W-1:0]      rsp_edge_value,
   output logic                           rsp_frame_end
);

   localparam int RW = kce_pkg::RESP_W;

   // stage 2: window
   logic                  s2_v_ff;
   kce_pkg::cmp_item_type s2_item_ff;
   // stage 3: eight responses
   logic                  s3_v_ff;
   logic signed [RW-1:0]  s3_resp_ff [8];
   logic                  s3_kirsch_ff;
   logic [kce_pkg::PIX_W-1:0] s3_pass_ff;
   logic                  s3_end_ff;
   // stage 4: best response and its index
   logic                  s4_v_ff;
   logic signed [RW-1:0]  s4_best_ff;
   logic [2:0]            s4_idx_ff;
   logic                  s4_kirsch_ff;
   logic [kce_pkg::PIX_W-1:0] s4_pass_ff;
   logic                  s4_end_ff;
   // result register
   logic                  out_v_ff;
   logic [kce_pkg::PIX_W-1:0] out_value_ff;
   logic                  out_end_ff;

   logic take_out, take4, take3, take2;

   logic signed [RW-1:0]  resp [8];
   logic signed [RW-1:0]  best;
   logic [2:0]            best_idx;
   logic [kce_pkg::PIX_W-1:0] value_in;

   assign take_out = !out_v_ff || rsp_ready;
   assign take4    = !s4_v_ff || take_out;
   assign take3    = !s3_v_ff || take4;
   assign take2    = !s2_v_ff || take3;
   assign in_ready = take2;

   // response of mask j is 5*(three ring pixels) - 3*(other five) = 8*trio - 3*ring
   always_comb begin : resp_calc
      logic [10:0] ring_sum;
      logic [9:0]  trio_sum;
      logic [2:0]  p;
      ring_sum = '0;
      for (int k = 0; k < 8; k++) begin
         ring_sum = ring_sum + 11'(s2_item_ff.win[kce_pkg::RING_POS[k]]);
      end
      for (int j = 0; j < 8; j++) begin
         p = 3'(2 - j);
         trio_sum = 10'(s2_item_ff.win[kce_pkg::RING_POS[p]])
                  + 10'(s2_item_ff.win[kce_pkg::RING_POS[p + 3'd1]])
                  + 10'(s2_item_ff.win[kce_pkg::RING_POS[p + 3'd2]]);
         resp[j] = RW'({trio_sum, 3'b000}) - RW'(ring_sum) - RW'({ring_sum, 1'b0});
      end
   end

   // arg-max tree, lower index kept on ties
   always_comb begin : argmax
      logic signed [RW-1:0] v1 [4];
      logic [2:0]           i1 [4];
      logic signed [RW-1:0] v2 [2];
      logic [2:0]           i2 [2];
      for (int k = 0; k < 4; k++) begin
         if (s3_resp_ff[2*k+1] > s3_resp_ff[2*k]) begin
            v1[k] = s3_resp_ff[2*k+1];
            i1[k] = 3'(2*k+1);
         end else begin
            v1[k] = s3_resp_ff[2*k];
            i1[k] = 3'(2*k);
         end
      end
      for (int k = 0; k < 2; k++) begin
         if (v1[2*k+1] > v1[2*k]) begin
            v2[k] = v1[2*k+1];
            i2[k] = i1[2*k+1];
         end else begin
            v2[k] = v1[2*k];
            i2[k] = i1[2*k];
         end
      end
      if (v2[1] > v2[0]) begin
         best     = v2[1];
         best_idx = i2[1];
      end else begin
         best     = v2[0];
         best_idx = i2[0];
      end
   end

   // best is never negative (the eight responses sum to zero), at most 3825
   always_comb begin : scale
      logic [27:0] prod;
      logic [11:0] mag;
      prod = 28'(s4_best_ff[12:0]) * 28'(kce_pkg::MAG_RECIP);
      mag  = prod[27:16];
      if (!s4_kirsch_ff) begin
         value_in = s4_pass_ff;
      end else if (mode) begin
         value_in = kce_pkg::DIR_CODE[s4_idx_ff];
      end else if (mag > 12'd255) begin
         value_in = 8'd255;
      end else begin
         value_in = mag[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (take2) s2_v_ff <= in_valid;
         if (take3) s3_v_ff <= s2_v_ff;
         if (take4) s4_v_ff <= s3_v_ff;
         if (take_out) out_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take2 && in_valid) begin
         s2_item_ff <= in_item;
      end
      if (take3 && s2_v_ff) begin
         s3_resp_ff   <= resp;
         s3_kirsch_ff <= s2_item_ff.kirsch;
         s3_pass_ff   <= s2_item_ff.pass_value;
         s3_end_ff    <= s2_item_ff.frame_end;
      end
      if (take4 && s3_v_ff) begin
         s4_best_ff   <= best;
         s4_idx_ff    <= best_idx;
         s4_kirsch_ff <= s3_kirsch_ff;
         s4_pass_ff   <= s3_pass_ff;
         s4_end_ff    <= s3_end_ff;
      end
      if (take_out && s4_v_ff) begin
         out_value_ff <= value_in;
         out_end_ff   <= s4_end_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_edge_value = out_value_ff;
   assign rsp_frame_end  = out_end_ff;

endmodule

`default_nettype wire

// ===== rtl/core/kirsch_compass_edge_top.sv =====
// kirsch_compass_edge_top: streaming 3x3 kirsch compass edge detector, top level.
// Depends on kce_pkg, kce_line_store and kce_compass.
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                   | dir | notes
// ----------+-----------------------------------------+-----+---------------------------
// request   | req_valid req_ready req_pixel req_drain | in  | one pixel or drain per item
// response  | rsp_valid rsp_ready rsp_edge_value      | out | zero or one item per request
//           | rsp_frame_end                           |     |
// csr       | csr_we csr_index csr_wdata              | in  | write only, no wait
//
// one item per clock sustained while rsp_ready holds; a result passes through stage 1,
// the compass window, response and arg-max stages and the output register. the rate
// is set by the line store, read once per item and written back once per item when
// it leaves stage 1. reset is synchronous and clears the control state and registers;
// line memories are not cleared, and an entry not yet written in a frame never reaches
// a result. a stall on rsp_ready fills the five stages before req_ready drops.

module kirsch_compass_edge_top #(
   parameter int MAX_WIDTH  = kce_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = kce_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [kce_pkg::PIX_W-1:0]       req_pixel,
   input  wire logic                            req_drain,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [kce_pkg::PIX_W-1:0]            rsp_edge_value,
   output logic                                 rsp_frame_end,
   // register writes
   input  wire logic                            csr_we,
   input  wire logic [kce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [kce_pkg::SIZE_W-1:0]      csr_wdata
);

   localparam int SW     = kce_pkg::SIZE_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int CCMP_W = (COL_W > SW) ? COL_W : SW;
   localparam int RCMP_W = (ROW_W > SW) ? ROW_W : SW;

   // size registers hold the last column / row index (size - 1)
   function automatic logic [SW-1:0] clamp_last(input logic [SW-1:0] v, input int hi);
      logic [SW-1:0] r;
      if (v < SW'(3)) begin
         r = SW'(2);
      end else if (int'(v) > hi) begin
         r = SW'(hi - 1);
      end else begin
         r = v - SW'(1);
      end
      return r;
   endfunction

   // configuration
   logic [SW-1:0] wlast_ff, hlast_ff;
   logic          mode_ff;
   logic          size_wr;

   // frame position
   logic [COL_W-1:0] in_col_ff,  in_col_in;
   logic [ROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   // accept-time decode
   logic accept;
   logic rows_open;     // frame still takes pixels
   logic pix_mode;      // item carries a pixel into the frame
   logic due_pix;       // pixel item that causes a result
   logic emit;          // item causes a result
   logic in_col_last, out_col_last, out_row_last, out_last;
   logic border;
   kce_pkg::src_type src_in;
   logic [COL_W-1:0] rd_addr;

   // window stage (stage 1)
   logic                      s1_v_ff;
   logic                      s1_pixel_ff;
   logic                      s1_due_ff;
   kce_pkg::src_type          s1_src_ff;
   logic                      s1_end_ff;
   logic [kce_pkg::PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0]          s1_addr_ff;
   logic                      s1_fwd_ff;
   logic [kce_pkg::PIX_W-1:0] fwd_upper_ff, fwd_middle_ff;
   logic                      s1_go;
   logic                      fwd_hit;

   kce_pkg::window_type       window_ff, window_in;
   logic [kce_pkg::PIX_W-1:0] ls_upper, ls_middle;
   logic [kce_pkg::PIX_W-1:0] eff_upper, eff_middle;
   logic [kce_pkg::PIX_W-1:0] pass_value;

   kce_pkg::cmp_item_type     cmp_item;
   logic                      cmp_valid, cmp_ready;

   //---------------------------------------------------------------------------
   // registers
   //---------------------------------------------------------------------------
   assign size_wr = csr_we && (csr_index == kce_pkg::REG_WIDTH ||
                               csr_index == kce_pkg::REG_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= kce_pkg::RESET_WIDTH - SW'(1);
         hlast_ff <= kce_pkg::RESET_HEIGHT - SW'(1);
         mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            kce_pkg::REG_WIDTH:  wlast_ff <= clamp_last(csr_wdata, MAX_WIDTH);
            kce_pkg::REG_HEIGHT: hlast_ff <= clamp_last(csr_wdata, MAX_HEIGHT);
            kce_pkg::REG_MODE:   mode_ff  <= csr_wdata[0];
            default: ;    // unknown index, ignored
         endcase
      end
   end

   //---------------------------------------------------------------------------
   // accept-time decode: all position bookkeeping happens here
   //---------------------------------------------------------------------------
   assign accept = req_valid && req_ready;

   assign rows_open    = RCMP_W'(in_row_ff) <= RCMP_W'(hlast_ff);
   assign pix_mode     = !req_drain && rows_open;
   assign due_pix      = (in_row_ff >= ROW_W'(2)) ||
                         (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   // a pixel past the frame's last one acts as a drain
   assign emit         = pix_mode ? due_pix : !rows_open;

   assign in_col_last  = CCMP_W'(in_col_ff)  >= CCMP_W'(wlast_ff);
   assign out_col_last = CCMP_W'(out_col_ff) >= CCMP_W'(wlast_ff);
   assign out_row_last = RCMP_W'(out_row_ff) >= RCMP_W'(hlast_ff);
   assign out_last     = out_col_last && out_row_last;
   assign border       = (out_row_ff == '0) || (out_col_ff == '0) ||
                         out_row_last || out_col_last;

   // pixel items: border value is the window center; drain items read the
   // line store row that holds the result row
   always_comb begin
      if (pix_mode) begin
         src_in  = border ? kce_pkg::SRC_CENTER : kce_pkg::SRC_KIRSCH;
         rd_addr = in_col_ff;
      end else begin
         src_in  = out_row_last ? kce_pkg::SRC_MIDDLE : kce_pkg::SRC_UPPER;
         rd_addr = out_col_ff;
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (size_wr) begin
         // a new frame size restarts the frame
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (pix_mode) begin
            if (in_col_last) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (emit) begin
            priority if (out_last) begin
               // frame done, next pixel starts a new one
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   //---------------------------------------------------------------------------
   // line store: read at accept, written back when the item leaves stage 1
   //---------------------------------------------------------------------------
   kce_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept && (pix_mode || emit)),
      .rd_addr   (rd_addr),
      .wr_en     (s1_go && s1_pixel_ff),
      .wr_addr   (s1_addr_ff),
      .wr_upper  (eff_middle),     // middle row moves up
      .wr_middle (s1_pix_ff),      // new pixel becomes the middle row
      .rd_upper  (ls_upper),
      .rd_middle (ls_middle)
   );

   // the write lands on the same edge as the read of the next item: if both hit
   // the same entry, carry the written data along instead of the stale read
   assign fwd_hit = s1_go && s1_pixel_ff && (s1_addr_ff == rd_addr);

   assign eff_upper  = s1_fwd_ff ? fwd_upper_ff  : ls_upper;
   assign eff_middle = s1_fwd_ff ? fwd_middle_ff : ls_middle;

   //---------------------------------------------------------------------------
   // stage 1: window shift and result source select
   //---------------------------------------------------------------------------
   // non-due pixel items leave without entering the compass pipeline
   assign s1_go     = s1_v_ff && (!s1_due_ff || cmp_ready);
   assign req_ready = !s1_v_ff || s1_go;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[3*r]     = window_ff[3*r + 1];
         window_in[3*r + 1] = window_ff[3*r + 2];
      end
      window_in[2] = eff_upper;
      window_in[5] = eff_middle;
      window_in[8] = s1_pix_ff;
   end

   always_comb begin
      unique case (s1_src_ff)
         kce_pkg::SRC_CENTER: pass_value = window_ff[5];    // center after the shift
         kce_pkg::SRC_UPPER:  pass_value = eff_upper;
         kce_pkg::SRC_MIDDLE: pass_value = eff_middle;
         default:             pass_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_ready) begin
         s1_v_ff <= accept && (pix_mode || emit);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff   <= pix_mode;
         s1_due_ff     <= emit;
         s1_src_ff     <= src_in;
         s1_end_ff     <= emit && out_last;
         s1_pix_ff     <= req_pixel;
         s1_addr_ff    <= rd_addr;
         s1_fwd_ff     <= fwd_hit;
         fwd_upper_ff  <= eff_middle;
         fwd_middle_ff <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || size_wr) begin
         window_ff <= '0;
      end else if (s1_go && s1_pixel_ff) begin
         window_ff <= window_in;
      end
   end

   //---------------------------------------------------------------------------
   // compass pipeline and result register
   //---------------------------------------------------------------------------
   assign cmp_valid = s1_v_ff && s1_due_ff;

   always_comb begin
      cmp_item.kirsch     = (s1_src_ff == kce_pkg::SRC_KIRSCH);
      cmp_item.pass_value = pass_value;
      cmp_item.frame_end  = s1_end_ff;
      cmp_item.win        = window_in;
   end

   kce_compass u_compass (
      .clock          (clock),
      .reset          (reset),
      .mode           (mode_ff),
      .in_valid       (cmp_valid),
      .in_ready       (cmp_ready),
      .in_item        (cmp_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== verif/kirsch_compass_edge_top_tb.sv =====
// kirsch_compass_edge_top_tb: self-checking bench for the streaming kirsch compass edge detector,
// with a bit-exact line-store/window predictor, random handshake gaps and register sweeps.
// Depends on kce_pkg and kirsch_compass_edge_top.
`timescale 1ns / 1ps

module kirsch_compass_edge_top_tb;
   import kce_pkg::*;

   // csr index with no register behind it, writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   localparam int unsigned RANDOM_ITEMS  = 1550;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned LIMIT_CYCLES  = 2_500_000;
   localparam int unsigned MAX_ERRORS_SHOWN = 40;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             drain;
   } pixel_item_t;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic             frame_end;
   } edge_result_t;

   typedef enum int {
      PAT_NOISE,
      PAT_BINARY,
      PAT_FLAT
   } pattern_kind_e;

   // dut ports
   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic                 req_drain = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIX_W-1:0]     rsp_edge_value;
   logic                 rsp_frame_end;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   // stimulus and scoreboard
   pixel_item_t  pixel_feed [$];
   edge_result_t expected_edges [$];
   pixel_item_t  next_item;
   bit           item_taken = 1'b0;
   int unsigned  send_gap = 0;
   int unsigned  send_quiet = 0;
   int unsigned  recv_stall = 0;
   int unsigned  recv_quiet = 0;
   int unsigned  fed_items = 0;
   int unsigned  results_checked = 0;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;

   // predictor state: configuration, line stores, window and stream positions
   int unsigned  cfg_width = 640;
   int unsigned  cfg_height = 480;
   bit           cfg_mode = 1'b0;
   logic [7:0]   upper_row [DEF_MAX_WIDTH];
   logic [7:0]   middle_row [DEF_MAX_WIDTH];
   logic [7:0]   win [9];
   int unsigned  in_col = 0;
   int unsigned  in_row = 0;
   int unsigned  out_col = 0;
   int unsigned  out_row = 0;

   kirsch_compass_edge_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_drain      (req_drain),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value),
      .rsp_frame_end  (rsp_frame_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------------

   task automatic restart_frame();
      for (int k = 0; k < 9; k++) win[k] = 8'd0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endtask

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] raw, int unsigned top);
      if (raw < 3) return 3;
      if (raw > top) return top;
      return raw;
   endfunction

   // pixel at (row, col) as held by the line stores before this item's write-back;
   // columns left of the input position already hold the current input row
   function automatic logic [7:0] stored_pixel(int unsigned row, int unsigned col);
      int unsigned latest;
      if (col < in_col) latest = in_row;
      else latest = (in_row > 0) ? in_row - 1 : 0;
      return (row == latest) ? middle_row[col] : upper_row[col];
   endfunction

   // queue one result at the output position and step that position
   task automatic emit_edge(input logic [7:0] value);
      edge_result_t res;
      bit           last;
      last = (out_row + 1 >= cfg_height) && (out_col + 1 >= cfg_width);
      res.value     = value;
      res.frame_end = last;
      expected_edges.push_back(res);
      if (last) begin
         restart_frame();
      end else if (out_col + 1 >= cfg_width) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // one accepted item: shift the window, write back the line stores, and queue the
   // result that this item releases (one row and one pixel behind the input)
   task automatic advance_detector(input logic [7:0] pix, input logic drn);
      logic [7:0]  top, mid, value;
      int unsigned col;
      int          ring [8];
      int          total, best, best_dir, resp;
      bit          due;
      if (!drn && in_row < cfg_height) begin
         col = in_col;
         due = (in_row >= 2) || (in_row == 1 && col >= 1);
         top = upper_row[col];
         mid = middle_row[col];
         for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = pix;
         value = 8'd0;
         if (due) begin
            if (out_row == 0 || out_col == 0 || out_row + 1 >= cfg_height ||
                out_col + 1 >= cfg_width) begin
               value = stored_pixel(out_row, out_col);
            end else begin
               // neighbors clockwise from top-left; compass d puts weight 5 on three
               // neighbors starting at ring slot (2 - d) mod 8 and -3 on the rest
               ring[0] = win[0]; ring[1] = win[1]; ring[2] = win[2]; ring[3] = win[5];
               ring[4] = win[8]; ring[5] = win[7]; ring[6] = win[6]; ring[7] = win[3];
               total = 0;
               for (int k = 0; k < 8; k++) total += ring[k];
               best     = -1;
               best_dir = 0;
               for (int d = 0; d < 8; d++) begin
                  resp = 8 * (ring[(10 - d) % 8] + ring[(11 - d) % 8] + ring[(12 - d) % 8])
                         - 3 * total;
                  if (resp > best) begin
                     best     = resp;
                     best_dir = d;
                  end
               end
               if (cfg_mode) begin
                  value = 8'((best_dir * 255) / 8);
               end else begin
                  best  = (best < 0) ? 0 : best / 3;
                  value = (best > 255) ? 8'd255 : 8'(best);
               end
            end
         end
         upper_row[col]  = mid;
         middle_row[col] = pix;
         if (col + 1 >= cfg_width) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col = col + 1;
         end
         if (due) emit_edge(value);
      end else if (in_row >= cfg_height) begin
         // all pixels of the frame are in: this item flushes one pending result
         emit_edge(stored_pixel(out_row, out_col));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // helpers for stimulus
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_ERRORS_SHOWN) $display("mismatch at %0t: %s", $time, what);
   endtask

   // mostly no gap, some short, a few long, and now and then a long quiet stretch
   function automatic int unsigned pick_gap(inout int unsigned quiet);
      int unsigned roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         quiet = $urandom_range(20, 100);
         return 0;
      end
      if (roll < 64) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size(int unsigned common_top,
                                                   int unsigned rare_top);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return SIZE_W'($urandom_range(3, common_top));
      if (roll < 95) return SIZE_W'($urandom_range(common_top + 1, rare_top));
      return SIZE_W'($urandom_range(0, 2));   // below range, must saturate to 3
   endfunction

   function automatic logic [7:0] make_pixel(pattern_kind_e kind, logic [7:0] base);
      case (kind)
         PAT_BINARY: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         PAT_FLAT:   return base + 8'($urandom_range(0, 2));
         default:    return 8'($urandom);
      endcase
   endfunction

   task automatic push_item(input logic [7:0] pix, input logic drn, input bit counted);
      pixel_item_t it;
      it.pixel = pix;
      it.drain = drn;
      pixel_feed.push_back(it);
      if (counted) fed_items++;
   endtask

   // block until every queued item is sent and every result is back, then let the
   // pipeline settle so that no item without a result is still in flight
   task automatic wait_idle();
      while (pixel_feed.size() != 0 || req_valid || expected_edges.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one-cycle register write; the predictor follows at once since the block is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WIDTH: begin
            cfg_width = clamp_size(data, DEF_MAX_WIDTH);
            restart_frame();
         end
         REG_HEIGHT: begin
            cfg_height = clamp_size(data, DEF_MAX_HEIGHT);
            restart_frame();
         end
         REG_MODE: cfg_mode = data[0];
         default: ;
      endcase
   endtask

   task automatic feed_fixed(input logic [8:0][7:0] img, input int first, input int last);
      for (int k = first; k <= last; k++) push_item(img[k], 1'b0, 1'b0);
   endtask

   // one full frame of pixels plus the width+1 flush items; noise drains land among the
   // pixels or after the flush, and a pause may stop the sender mid-frame for a mode change
   task automatic feed_frame(input bit with_noise, input bit with_pause);
      int unsigned   total, pause_at;
      pattern_kind_e kind;
      logic [7:0]    base;
      total    = cfg_width * cfg_height;
      kind     = pattern_kind_e'($urandom_range(0, 2));
      base     = 8'($urandom_range(0, 253));
      pause_at = total;
      if (with_pause && $urandom_range(0, 99) < 10) pause_at = $urandom_range(1, total - 1);
      for (int unsigned k = 0; k < total; k++) begin
         if (k == pause_at) begin
            wait_idle();
            if ($urandom_range(0, 1)) write_csr(REG_MODE, SIZE_W'($urandom));
         end
         if (with_noise && $urandom_range(0, 99) < 3) push_item(8'($urandom), 1'b1, 1'b0);
         push_item(make_pixel(kind, base), 1'b0, 1'b1);
      end
      // a pixel sent after the frame is complete is dropped and flushes like a drain
      for (int unsigned k = 0; k <= cfg_width; k++)
         push_item(8'($urandom), $urandom_range(0, 99) < 80, 1'b1);
      if (with_noise && $urandom_range(0, 99) < 20) push_item(8'($urandom), 1'b1, 1'b0);
   endtask

   // ---------------------------------------------------------------------------------------
   // request driver: changes at the falling edge, holds valid and payload until taken
   // ---------------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || item_taken) begin
         if (item_taken) begin
            item_taken = 1'b0;
            send_gap   = pick_gap(send_quiet);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixel_feed.size() != 0) begin
            next_item = pixel_feed.pop_front();
            req_valid <= 1'b1;
            req_pixel <= next_item.pixel;
            req_drain <= next_item.drain;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, independent of traffic so stalls hit every pipeline phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         recv_stall = pick_gap(recv_quiet);
      end
   end

   // ---------------------------------------------------------------------------------------
   // monitor: at the rising edge, feed accepted items to the predictor and check results
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      edge_result_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_detector(req_pixel, req_drain);
            item_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_edges.size() == 0) begin
               report_mismatch($sformatf("unexpected result value %0d frame_end %0d",
                                         rsp_edge_value, rsp_frame_end));
            end else begin
               want = expected_edges.pop_front();
               if (rsp_edge_value !== want.value)
                  report_mismatch($sformatf("result %0d edge_value %0d, want %0d",
                                            results_checked, rsp_edge_value, want.value));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("result %0d frame_end %0d, want %0d",
                                            results_checked, rsp_frame_end, want.frame_end));
            end
            results_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("kirsch_compass_edge_top_tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      int unsigned   span;
      pattern_kind_e kind;
      logic [7:0]    base;

      for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
         upper_row[k]  = 8'd0;
         middle_row[k] = 8'd0;
      end
      restart_frame();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // smallest frame: sizes below range saturate to 3, mode takes bit 0 only,
      // the spare index must change nothing
      write_csr(REG_WIDTH, 12'd0);
      write_csr(REG_HEIGHT, 12'd2);
      write_csr(REG_MODE, 12'hFFE);
      write_csr(REG_SPARE, 12'h5A5);

      // drain on an empty pipe gives nothing
      push_item(8'h00, 1'b1, 1'b0);
      // bright right column, strongest east response, magnitude clips to 255;
      // a drain in the middle of the frame is ignored
      feed_fixed({8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 0, 4);
      push_item(8'hFF, 1'b1, 1'b0);
      feed_fixed({8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 5, 8);
      // flush: a pixel past the end acts as a drain, then plain drains
      push_item(8'hA5, 1'b0, 1'b0);
      repeat (3) push_item(8'h00, 1'b1, 1'b0);
      push_item(8'h3C, 1'b1, 1'b0);

      // bright top row; sender pauses until all results are back, then direction
      // mode is switched on before the only interior result
      feed_fixed({{6{8'd0}}, {3{8'd255}}}, 0, 7);
      wait_idle();
      write_csr(REG_MODE, 12'hFFF);
      feed_fixed({{6{8'd0}}, {3{8'd255}}}, 8, 8);
      repeat (4) push_item(8'h00, 1'b1, 1'b0);

      // random frames, mostly small, with occasional reconfiguration and broken frames
      fed_items = 0;
      while (fed_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 35) begin
            wait_idle();
            write_csr(REG_WIDTH, pick_size(12, 48));
            write_csr(REG_HEIGHT, pick_size(8, 16));
            write_csr(REG_MODE, SIZE_W'($urandom));
            if ($urandom_range(0, 99) < 15) write_csr(REG_SPARE, SIZE_W'($urandom));
         end
         if ($urandom_range(0, 99) < 10) begin
            // partial frame, then a size write throws it away and restarts
            span = $urandom_range(1, cfg_width * cfg_height - 1);
            kind = pattern_kind_e'($urandom_range(0, 2));
            base = 8'($urandom_range(0, 253));
            for (int unsigned k = 0; k < span; k++) push_item(make_pixel(kind, base), 1'b0, 1'b1);
            wait_idle();
            if ($urandom_range(0, 1)) write_csr(REG_WIDTH, SIZE_W'(cfg_width));
            else write_csr(REG_HEIGHT, SIZE_W'(cfg_height));
         end else begin
            feed_frame(1'b1, 1'b1);
         end
      end

      // largest sizes: oversize writes saturate, one full-width and one full-height frame
      wait_idle();
      write_csr(REG_WIDTH, 12'hFFF);
      write_csr(REG_HEIGHT, 12'd1);
      write_csr(REG_MODE, 12'd0);
      feed_frame(1'b0, 1'b0);
      wait_idle();
      write_csr(REG_HEIGHT, 12'hFFF);
      write_csr(REG_WIDTH, 12'd3);
      write_csr(REG_MODE, 12'd1);
      feed_frame(1'b0, 1'b0);

      wait_idle();
      if (expected_edges.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_edges.size()));
      if (error_count == 0) begin
         $display("kirsch_compass_edge_top_tb OK");
      end else begin
         $display("kirsch_compass_edge_top_tb NOT OK");
      end
      $finish;
   end

endmodule
